// ===== design/fpp_pkg.sv =====
// Shared types and constants of the framebuffer pixel packer.
package fpp_pkg;

	// Build options
	localparam int BIG_ENDIAN_ORDER = 0;
	localparam int MAX_COORD        = 4096;

	// Field widths
	localparam int CHAN_W   = 8;
	localparam int COORD_W  = 12;
	localparam int OFF_W    = 5;
	localparam int LEN_W    = 4;
	localparam int STRIDE_W = 15;
	localparam int MODE_W   = 2;
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 3;
	localparam int ADDR_W   = 26;
	localparam int XOFF_W   = COORD_W + 2;
	localparam int PROD_W   = COORD_W + STRIDE_W;

	// Pixel modes; the unused code behaves as 16/15 bpp
	localparam logic [MODE_W-1:0] MODE_32 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_24 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_16 = 2'd2;

	// Byte counts
	localparam logic [COUNT_W-1:0] BYTES_32 = 3'd4;
	localparam logic [COUNT_W-1:0] BYTES_24 = 3'd3;
	localparam logic [COUNT_W-1:0] BYTES_16 = 3'd2;

	// Register indexes
	localparam logic [2:0] REG_PIXEL_MODE   = 3'd0;
	localparam logic [2:0] REG_RED_OFFSET   = 3'd1;
	localparam logic [2:0] REG_GREEN_OFFSET = 3'd2;
	localparam logic [2:0] REG_BLUE_OFFSET  = 3'd3;
	localparam logic [2:0] REG_RED_LENGTH   = 3'd4;
	localparam logic [2:0] REG_GREEN_LENGTH = 3'd5;
	localparam logic [2:0] REG_BLUE_LENGTH  = 3'd6;
	localparam logic [2:0] REG_LINE_STRIDE  = 3'd7;

	// Channel bit positions handed to the placer
	typedef struct packed {
		logic [OFF_W-1:0] red_off;
		logic [OFF_W-1:0] green_off;
		logic [OFF_W-1:0] blue_off;
	} offsets_t;

endpackage

// ===== design/fpp_place.sv =====
// Shifts the three channels to their bit positions and merges them.
module fpp_place (
	input  logic [fpp_pkg::CHAN_W-1:0] red,
	input  logic [fpp_pkg::CHAN_W-1:0] green,
	input  logic [fpp_pkg::CHAN_W-1:0] blue,
	input  fpp_pkg::offsets_t          offsets,
	output logic [fpp_pkg::WORD_W-1:0] word
);

	localparam int PAD_W = fpp_pkg::WORD_W - fpp_pkg::CHAN_W;

	logic [fpp_pkg::WORD_W-1:0] red_w;
	logic [fpp_pkg::WORD_W-1:0] green_w;
	logic [fpp_pkg::WORD_W-1:0] blue_w;

	// bits pushed past the top are dropped
	assign red_w   = {{PAD_W{1'b0}}, red}   << offsets.red_off;
	assign green_w = {{PAD_W{1'b0}}, green} << offsets.green_off;
	assign blue_w  = {{PAD_W{1'b0}}, blue}  << offsets.blue_off;
	assign word    = red_w | green_w | blue_w;

endmodule

// ===== design/framebuffer_pixel_packer_top.sv =====
// Top level of the framebuffer pixel packer: registers and three-stage pipeline.
//
// channel   dir  payload                                    handshake
// s_*       in   red, green, blue, pixel_x, pixel_y         s_tvalid / s_tready
// m_*       out  packed_word, byte_count, byte_address      m_tvalid / m_tready
// cfg_*     in   register index, write data                 cfg_we, no wait
//
// One item per clock sustained while m_tready stays high; an accepted item
// passes through the stage 1, 2 and 3 registers before m_tvalid. Stage 1
// clamps coordinates, trims channels in 16 bpp mode and forms x*bpp;
// stage 2 places the channels and multiplies y by the line stride; stage 3
// orders the bytes and adds the address. Each stage holds while the one
// after it is full and stalled, so s_tready drops only when all three are
// full and m_tready is low. Reset empties the pipeline and loads the register defaults.
module framebuffer_pixel_packer_top #(
	parameter int BIG_ENDIAN_ORDER = fpp_pkg::BIG_ENDIAN_ORDER,
	parameter int MAX_COORD        = fpp_pkg::MAX_COORD
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16],
	                               // pixel_x[35:24], pixel_y[47:36]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // packed_word[31:0], byte_count[34:32],
	                               // byte_address[60:35], zero[63:61]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	localparam int CW = fpp_pkg::CHAN_W;
	localparam int XW = fpp_pkg::COORD_W;

	// largest coordinate that can leave the clamp
	localparam int CLAMP_MAX = (MAX_COORD > (1 << XW)) ? ((1 << XW) - 1)
	                                                   : (MAX_COORD - 1);

	// ---------------- configuration registers ----------------
	logic [fpp_pkg::MODE_W-1:0]   pixel_mode_q;
	logic [fpp_pkg::OFF_W-1:0]    red_offset_q, green_offset_q, blue_offset_q;
	logic [fpp_pkg::LEN_W-1:0]    red_length_q, green_length_q, blue_length_q;
	logic [fpp_pkg::STRIDE_W-1:0] line_stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q   <= fpp_pkg::MODE_32;
			red_offset_q   <= 5'd16;
			green_offset_q <= 5'd8;
			blue_offset_q  <= 5'd0;
			red_length_q   <= 4'd5;
			green_length_q <= 4'd6;
			blue_length_q  <= 4'd5;
			line_stride_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fpp_pkg::REG_PIXEL_MODE:   pixel_mode_q   <= cfg_data[1:0];
				fpp_pkg::REG_RED_OFFSET:   red_offset_q   <= cfg_data[4:0];
				fpp_pkg::REG_GREEN_OFFSET: green_offset_q <= cfg_data[4:0];
				fpp_pkg::REG_BLUE_OFFSET:  blue_offset_q  <= cfg_data[4:0];
				fpp_pkg::REG_RED_LENGTH:   red_length_q   <= cfg_data[3:0];
				fpp_pkg::REG_GREEN_LENGTH: green_length_q <= cfg_data[3:0];
				fpp_pkg::REG_BLUE_LENGTH:  blue_length_q  <= cfg_data[3:0];
				fpp_pkg::REG_LINE_STRIDE:  line_stride_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// ---------------- stage 1: clamp, trim, x offset ----------------
	logic [CW-1:0] red_in, green_in, blue_in;
	logic [XW-1:0] pixel_x, pixel_y, x_clamp, y_clamp;
	logic [CW-1:0] red_trim, green_trim, blue_trim;
	logic          mode16;
	logic [fpp_pkg::COUNT_W-1:0] bpp;
	logic [fpp_pkg::XOFF_W-1:0]  x_ext, x_bytes;

	assign red_in   = s_tdata[7:0];
	assign green_in = s_tdata[15:8];
	assign blue_in  = s_tdata[23:16];
	assign pixel_x  = s_tdata[35:24];
	assign pixel_y  = s_tdata[47:36];

	// coordinates at or past the screen edge stick to the last column/row
	assign x_clamp = ({3'b000, pixel_x} >= 15'(MAX_COORD)) ?
	                 XW'(CLAMP_MAX) : pixel_x;
	assign y_clamp = ({3'b000, pixel_y} >= 15'(MAX_COORD)) ?
	                 XW'(CLAMP_MAX) : pixel_y;

	// keep the top bits; a length above 8 keeps all, zero keeps none
	function automatic logic [CW-1:0] trim(input logic [CW-1:0] chan,
	                                       input logic [fpp_pkg::LEN_W-1:0] len);
		logic [fpp_pkg::LEN_W-1:0] n;
		n = (len > 4'd8) ? 4'd8 : len;
		return chan >> (4'd8 - n);
	endfunction

	assign mode16     = (pixel_mode_q != fpp_pkg::MODE_32) &&
	                    (pixel_mode_q != fpp_pkg::MODE_24);
	assign red_trim   = mode16 ? trim(red_in, red_length_q)     : red_in;
	assign green_trim = mode16 ? trim(green_in, green_length_q) : green_in;
	assign blue_trim  = mode16 ? trim(blue_in, blue_length_q)   : blue_in;

	always_comb begin
		x_ext = {2'b00, x_clamp};
		case (pixel_mode_q)
			fpp_pkg::MODE_32: begin
				bpp     = fpp_pkg::BYTES_32;
				x_bytes = x_ext << 2;
			end
			fpp_pkg::MODE_24: begin
				bpp     = fpp_pkg::BYTES_24;
				x_bytes = (x_ext << 1) + x_ext;
			end
			default: begin
				bpp     = fpp_pkg::BYTES_16;
				x_bytes = x_ext << 1;
			end
		endcase
	end

	logic [CW-1:0] red_s1, green_s1, blue_s1;
	logic [XW-1:0] y_s1;
	logic [fpp_pkg::COUNT_W-1:0] bpp_s1;
	logic [fpp_pkg::XOFF_W-1:0]  xb_s1;

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			red_s1   <= red_trim;
			green_s1 <= green_trim;
			blue_s1  <= blue_trim;
			y_s1     <= y_clamp;
			bpp_s1   <= bpp;
			xb_s1    <= x_bytes;
		end
	end

	// ---------------- stage 2: place channels, y * stride ----------------
	fpp_pkg::offsets_t offsets;
	logic [fpp_pkg::WORD_W-1:0] placed;

	assign offsets = '{red_off: red_offset_q, green_off: green_offset_q,
	                   blue_off: blue_offset_q};

	fpp_place u_place (
		.red     (red_s1),
		.green   (green_s1),
		.blue    (blue_s1),
		.offsets (offsets),
		.word    (placed)
	);

	logic [fpp_pkg::WORD_W-1:0]  placed_s2;
	logic [CW-1:0]               red_s2, green_s2, blue_s2;
	logic [fpp_pkg::PROD_W-1:0]  prod_s2;
	logic [fpp_pkg::COUNT_W-1:0] bpp_s2;
	logic [fpp_pkg::XOFF_W-1:0]  xb_s2;

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			placed_s2 <= placed;
			red_s2    <= red_s1;
			green_s2  <= green_s1;
			blue_s2   <= blue_s1;
			prod_s2   <= {{fpp_pkg::STRIDE_W{1'b0}}, y_s1} *
			             {{XW{1'b0}}, line_stride_q};
			bpp_s2    <= bpp_s1;
			xb_s2     <= xb_s1;
		end
	end

	// ---------------- stage 3: byte order, address ----------------
	logic [fpp_pkg::WORD_W-1:0] word;
	logic [fpp_pkg::ADDR_W-1:0] addr;

	always_comb begin
		case (bpp_s2)
			fpp_pkg::BYTES_32: begin
				word = (BIG_ENDIAN_ORDER != 0) ?
				       {placed_s2[7:0], placed_s2[15:8], placed_s2[23:16],
				        placed_s2[31:24]} : placed_s2;
			end
			fpp_pkg::BYTES_24: begin
				word = (BIG_ENDIAN_ORDER != 0) ?
				       {8'h00, blue_s2, green_s2, red_s2} :
				       {8'h00, red_s2, green_s2, blue_s2};
			end
			default: begin
				word = (BIG_ENDIAN_ORDER != 0) ?
				       {16'h0000, placed_s2[7:0], placed_s2[15:8]} :
				       {16'h0000, placed_s2[15:0]};
			end
		endcase
	end

	// wraps modulo 2^26
	assign addr = prod_s2[fpp_pkg::ADDR_W-1:0] +
	              {{(fpp_pkg::ADDR_W - fpp_pkg::XOFF_W){1'b0}}, xb_s2};

	logic [fpp_pkg::WORD_W-1:0]  word_s3;
	logic [fpp_pkg::COUNT_W-1:0] bpp_s3;
	logic [fpp_pkg::ADDR_W-1:0]  addr_s3;

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			word_s3 <= word;
			bpp_s3  <= bpp_s2;
			addr_s3 <= addr;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {3'b000, addr_s3, bpp_s3, word_s3};

endmodule
